### hw/rtl/rip_pkg.sv
`default_nettype none

package rip_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [5:0]  RESET_BASE = 6'd10;
   localparam logic [5:0]  BASE_HEX   = 6'd16;
   localparam logic [5:0]  BASE_BIN   = 6'd2;

   localparam logic [63:0] POS_LIMIT  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_LIMIT  = 64'h8000_0000_0000_0000;

   localparam logic [7:0]  CHAR_SPACE  = 8'h20;
   localparam logic [7:0]  CHAR_TAB    = 8'h09;
   localparam logic [7:0]  CHAR_CR     = 8'h0D;
   localparam logic [7:0]  CHAR_PLUS   = 8'h2B;
   localparam logic [7:0]  CHAR_MINUS  = 8'h2D;
   localparam logic [7:0]  CHAR_ZERO   = 8'h30;
   localparam logic [7:0]  CHAR_NINE   = 8'h39;
   localparam logic [7:0]  CHAR_LOW_A  = 8'h61;
   localparam logic [7:0]  CHAR_LOW_Z  = 8'h7A;
   localparam logic [7:0]  CHAR_UP_A   = 8'h41;
   localparam logic [7:0]  CHAR_UP_Z   = 8'h5A;
   localparam logic [7:0]  CHAR_LOW_X  = 8'h78;
   localparam logic [7:0]  CHAR_LOW_B  = 8'h62;
   localparam logic [7:0]  CASE_BIT    = 8'h20;
   localparam logic [7:0]  LOW_OFFSET  = 8'h57;
   localparam logic [7:0]  UP_OFFSET   = 8'h37;

   typedef struct packed {
      logic       digit_ok;
      logic [5:0] digit_val;
      logic       space;
      logic       plus;
      logic       minus;
      logic       zero;
      logic       prefix;
      logic       has;
      logic       last;
      logic [5:0] radix;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

### hw/rtl/rip_front.sv
`default_nettype none

module rip_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         req_text_byte,
   input  wire logic               req_has_byte,
   input  wire logic [5:0]         req_number_base,
   input  wire logic               req_last_byte,
   input  wire logic               req_push,
   input  wire rip_pkg::qstat_type q_stat,
   output logic                    q_push,
   output rip_pkg::item_type       q_item
);

   logic [5:0] base_ff, base_in;
   logic       in_text_ff, in_text_in;
   logic [5:0] base_w;
   logic [7:0] c_w, low_w, tmp_w;
   logic       alnum_w;

   assign q_push = req_push && !q_stat.full;
   assign c_w    = req_text_byte;
   assign low_w  = c_w | rip_pkg::CASE_BIT;
   assign base_w = in_text_ff ? base_ff : req_number_base;

   always_comb begin
      alnum_w = 1'b1;
      tmp_w   = c_w - rip_pkg::CHAR_ZERO;
      if (c_w >= rip_pkg::CHAR_ZERO && c_w <= rip_pkg::CHAR_NINE) begin
         tmp_w = c_w - rip_pkg::CHAR_ZERO;
      end else if (c_w >= rip_pkg::CHAR_LOW_A && c_w <= rip_pkg::CHAR_LOW_Z) begin
         tmp_w = c_w - rip_pkg::LOW_OFFSET;
      end else if (c_w >= rip_pkg::CHAR_UP_A && c_w <= rip_pkg::CHAR_UP_Z) begin
         tmp_w = c_w - rip_pkg::UP_OFFSET;
      end else begin
         alnum_w = 1'b0;
      end
   end

   always_comb begin
      q_item.digit_val = tmp_w[5:0];
      q_item.digit_ok  = alnum_w && (tmp_w[5:0] < base_w);
      q_item.space     = (c_w == rip_pkg::CHAR_SPACE) ||
                         (c_w >= rip_pkg::CHAR_TAB && c_w <= rip_pkg::CHAR_CR);
      q_item.plus      = (c_w == rip_pkg::CHAR_PLUS);
      q_item.minus     = (c_w == rip_pkg::CHAR_MINUS);
      q_item.zero      = (c_w == rip_pkg::CHAR_ZERO);
      q_item.prefix    = (base_w == rip_pkg::BASE_HEX && low_w == rip_pkg::CHAR_LOW_X) ||
                         (base_w == rip_pkg::BASE_BIN && low_w == rip_pkg::CHAR_LOW_B);
      q_item.has       = req_has_byte;
      q_item.last      = req_last_byte;
      q_item.radix     = base_w;
   end

   always_comb begin
      base_in    = base_ff;
      in_text_in = in_text_ff;
      if (q_push) begin
         base_in    = base_w;
         in_text_in = !req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= rip_pkg::RESET_BASE;
         in_text_ff <= 1'b0;
      end else begin
         base_ff    <= base_in;
         in_text_ff <= in_text_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/rip_queue.sv
`default_nettype none

module rip_queue #(
   parameter int unsigned DEPTH = rip_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rip_pkg::item_type wr_item,
   input  wire logic              pop,
   output rip_pkg::item_type      rd_item,
   output rip_pkg::qstat_type     stat
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rip_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign rd_item    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/rip_back.sv
`default_nettype none

module rip_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rip_pkg::item_type  q_item,
   input  wire rip_pkg::qstat_type q_stat,
   output logic                    q_pop,
   input  wire logic               rsp_pop,
   output logic                    rsp_empty,
   output logic                    rsp_parse_status,
   output logic signed [63:0]      rsp_signed_value,
   output logic                    rsp_signed_out_of_range,
   output logic [63:0]             rsp_unsigned_value,
   output logic                    rsp_unsigned_error
);

   typedef enum logic [5:0] {
      PH_LEAD   = 6'b000001,
      PH_SIGN   = 6'b000010,
      PH_PREFIX = 6'b000100,
      PH_DIGITS = 6'b001000,
      PH_TRAIL  = 6'b010000,
      PH_ERROR  = 6'b100000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [63:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        ovf_ff, ovf_in;
   logic        seen_ff, seen_in;
   logic        lone_ff, lone_in;

   logic        out_full_ff, out_full_in;
   logic        out_valid_ff, out_valid_in;
   logic        out_neg_ff, out_neg_in;
   logic        out_ovf_ff, out_ovf_in;
   logic [63:0] out_mag_ff, out_mag_in;

   logic [69:0] prod_w;
   logic [70:0] sum_w;
   logic        sum_ovf_w;
   logic        out_free_w;
   logic        take_digit_w;

   assign out_free_w = !out_full_ff || rsp_pop;
   assign q_pop      = !q_stat.empty && (!q_item.last || out_free_w);

   assign prod_w    = {6'd0, acc_ff} * {64'd0, q_item.radix};
   assign sum_w     = {1'b0, prod_w} + {65'd0, q_item.digit_val};
   assign sum_ovf_w = |sum_w[70:64];

   always_comb begin
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      ovf_in       = ovf_ff;
      seen_in      = seen_ff;
      lone_in      = lone_ff;
      take_digit_w = 1'b0;

      if (q_pop && q_item.has) begin
         case (phase_ff)
            PH_LEAD: begin
               if (q_item.space) begin
                  phase_in = PH_LEAD;
               end else if (q_item.plus || q_item.minus) begin
                  neg_in   = q_item.minus;
                  phase_in = PH_SIGN;
               end else if (q_item.digit_ok) begin
                  take_digit_w = 1'b1;
                  lone_in      = q_item.zero;
                  phase_in     = PH_DIGITS;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_SIGN: begin
               if (q_item.digit_ok) begin
                  take_digit_w = 1'b1;
                  lone_in      = q_item.zero;
                  phase_in     = PH_DIGITS;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_PREFIX: begin
               if (q_item.digit_ok) begin
                  take_digit_w = 1'b1;
                  phase_in     = PH_DIGITS;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_DIGITS: begin
               if (lone_ff && q_item.prefix) begin
                  lone_in  = 1'b0;
                  seen_in  = 1'b0;
                  acc_in   = '0;
                  phase_in = PH_PREFIX;
               end else if (q_item.digit_ok) begin
                  lone_in      = 1'b0;
                  take_digit_w = 1'b1;
               end else if (q_item.space) begin
                  phase_in = PH_TRAIL;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_TRAIL: begin
               if (!q_item.space) begin
                  phase_in = PH_ERROR;
               end
            end
            default: begin
               phase_in = PH_ERROR;
            end
         endcase
      end

      if (take_digit_w) begin
         seen_in = 1'b1;
         if (!ovf_ff) begin
            if (sum_ovf_w) begin
               ovf_in = 1'b1;
            end else begin
               acc_in = sum_w[63:0];
            end
         end
      end
   end

   always_comb begin
      out_full_in  = out_full_ff && !rsp_pop;
      out_valid_in = out_valid_ff;
      out_neg_in   = out_neg_ff;
      out_ovf_in   = out_ovf_ff;
      out_mag_in   = out_mag_ff;
      if (q_pop && q_item.last) begin
         out_full_in  = 1'b1;
         out_valid_in = seen_in && (phase_in == PH_DIGITS || phase_in == PH_TRAIL);
         out_neg_in   = neg_in;
         out_ovf_in   = ovf_in;
         out_mag_in   = acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (q_pop && q_item.last)) begin
         phase_ff <= PH_LEAD;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         lone_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         ovf_ff   <= ovf_in;
         seen_ff  <= seen_in;
         lone_ff  <= lone_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else begin
         out_full_ff <= out_full_in;
      end
   end

   always_ff @(posedge clock) begin
      out_valid_ff <= out_valid_in;
      out_neg_ff   <= out_neg_in;
      out_ovf_ff   <= out_ovf_in;
      out_mag_ff   <= out_mag_in;
   end

   assign rsp_empty = !out_full_ff;

   always_comb begin
      rsp_parse_status        = 1'b1;
      rsp_signed_value        = '0;
      rsp_signed_out_of_range = 1'b0;
      rsp_unsigned_value      = '0;
      rsp_unsigned_error      = 1'b1;
      if (out_valid_ff) begin
         rsp_parse_status   = 1'b0;
         rsp_unsigned_value = out_mag_ff;
         rsp_unsigned_error = out_neg_ff || out_ovf_ff;
         if (out_neg_ff) begin
            if (out_ovf_ff || (out_mag_ff[63] && (|out_mag_ff[62:0]))) begin
               rsp_signed_value        = rip_pkg::NEG_LIMIT;
               rsp_signed_out_of_range = 1'b1;
            end else begin
               rsp_signed_value = ~out_mag_ff + 64'd1;
            end
         end else begin
            if (out_ovf_ff || out_mag_ff[63]) begin
               rsp_signed_value        = rip_pkg::POS_LIMIT;
               rsp_signed_out_of_range = 1'b1;
            end else begin
               rsp_signed_value = out_mag_ff;
            end
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/radix_integer_text_parser.sv
`default_nettype none

// Channel   Direction  Handshake        Payload
// req_      in         push / full      text_byte, has_byte, number_base, last_byte
// rsp_      out        empty / pop      parse_status, signed_value, signed_out_of_range,
//                                       unsigned_value, unsigned_error
//
// One item per cycle unless a last item stalls: the back scanner's 64 by 6 bit multiply-add
// takes one digit a cycle. A result is registered for rsp_ as its last item leaves the queue.
// A last item waits at the queue head while the result register holds an untaken result.
// Synchronous reset empties the queue and the result register and sets the radix to ten.

module radix_integer_text_parser #(
   parameter int unsigned QUEUE_DEPTH = rip_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         req_text_byte,
   input  wire logic               req_has_byte,
   input  wire logic [5:0]         req_number_base,
   input  wire logic               req_last_byte,
   input  wire logic               req_push,
   output logic                    req_full,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic                    rsp_parse_status,
   output logic signed [63:0]      rsp_signed_value,
   output logic                    rsp_signed_out_of_range,
   output logic [63:0]             rsp_unsigned_value,
   output logic                    rsp_unsigned_error
);

   rip_pkg::item_type  wr_item;
   rip_pkg::item_type  rd_item;
   rip_pkg::qstat_type q_stat;
   logic               q_push;
   logic               q_pop;

   assign req_full = q_stat.full;

   rip_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_text_byte   (req_text_byte),
      .req_has_byte    (req_has_byte),
      .req_number_base (req_number_base),
      .req_last_byte   (req_last_byte),
      .req_push        (req_push),
      .q_stat          (q_stat),
      .q_push          (q_push),
      .q_item          (wr_item)
   );

   rip_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_item (wr_item),
      .pop     (q_pop),
      .rd_item (rd_item),
      .stat    (q_stat)
   );

   rip_back u_back (
      .clock                   (clock),
      .reset                   (reset),
      .q_item                  (rd_item),
      .q_stat                  (q_stat),
      .q_pop                   (q_pop),
      .rsp_pop                 (rsp_pop),
      .rsp_empty               (rsp_empty),
      .rsp_parse_status        (rsp_parse_status),
      .rsp_signed_value        (rsp_signed_value),
      .rsp_signed_out_of_range (rsp_signed_out_of_range),
      .rsp_unsigned_value      (rsp_unsigned_value),
      .rsp_unsigned_error      (rsp_unsigned_error)
   );

endmodule

`default_nettype wire

### hw/rtl/rip_checker.sv
`default_nettype none

module rip_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_push,
   input wire logic               req_full,
   input wire logic               rsp_empty,
   input wire logic               rsp_pop,
   input wire logic               rsp_parse_status,
   input wire logic signed [63:0] rsp_signed_value,
   input wire logic               rsp_signed_out_of_range,
   input wire logic [63:0]        rsp_unsigned_value,
   input wire logic               rsp_unsigned_error
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_signed_value) &&
                                    $stable(rsp_unsigned_value) && $stable(rsp_parse_status)))
      else $error("stalled item changed");

   a_invalid_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_parse_status) |-> (rsp_signed_value == 64'sd0 &&
         rsp_unsigned_value == 64'd0 && rsp_unsigned_error && !rsp_signed_out_of_range))
      else $error("invalid item carries data");

   a_plain_value: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_parse_status && !rsp_unsigned_error) |->
         (!rsp_unsigned_value[63] == !rsp_signed_out_of_range &&
          (rsp_signed_out_of_range || rsp_signed_value == rsp_unsigned_value)))
      else $error("positive value mismatch");

   a_saturate: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_signed_out_of_range) |->
         (rsp_signed_value == 64'sh7FFF_FFFF_FFFF_FFFF ||
          rsp_signed_value == 64'sh8000_0000_0000_0000))
      else $error("saturated value not at a limit");

endmodule

bind radix_integer_text_parser rip_checker u_rip_checker (.*);

`default_nettype wire
